/* src/fpba_pkg.sv */
// Package for the fit-policy block allocator.
// Holds item and register codes, field widths and the control struct
// that the top level sends to the selection unit. Has no dependencies.
`default_nettype none

package fpba_pkg;

  // Field widths of the stream items and configuration registers
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BIDX_W  = 4;
  localparam int unsigned FSIZE_W = 16;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned BCNT_W  = 5;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned CFGA_W  = 1;

  // Item kinds carried in tuser
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;

  // Placement policies; unused codes behave as first fit
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [CFGA_W-1:0] REG_FIT_MODE    = 1'd0;
  localparam logic [CFGA_W-1:0] REG_BLOCK_COUNT = 1'd1;

  // Reset values of the configuration registers
  localparam logic [MODE_W-1:0] FIT_MODE_RST    = MODE_FIRST;
  localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

  // Control from the sequencer to the selection unit
  typedef struct packed {
    logic clear;   // start a new search
    logic sample;  // a candidate entry is on the data inputs
  } pick_ctrl_t;

endpackage

`default_nettype wire

/* src/fit_policy_block_allocator.sv */
// Fit-policy block allocator, top level: stream ports, configuration
// registers, sequencer and the two size tables. Uses fpba_pkg, fpba_ram
// and fpba_pick.
//
// Usage:
//   Items enter on the s_axis channel; the item kind sits in tuser. Every
//   item gives exactly one result on the m_axis channel (granted in tuser,
//   block index and space left in tdata); load, restore and unknown kinds
//   give an all-zero result.
//   Both tables live in synchronous RAMs with registered reads; an allocate
//   reads the free-space table one entry a cycle, keeps the best candidate,
//   then writes the reduced free space back. Restore copies the loaded table
//   one entry a cycle through the RAM read latency. The scan of one RAM read
//   port per entry sets the time an item takes: an allocate scans
//   L = min(block_count, NUM_BLOCKS) entries, a restore NUM_BLOCKS entries.
//   One item at a time.
//   A finished result waits in the output register while the next item is
//   accepted; if the receiver stalls, the block holds a second finished
//   result internally and stops accepting until the output frees up.
//   Reset empties both tables (per-entry valid bits, invalid reads as zero),
//   sets fit_mode to first fit and block_count to 16. Configuration writes
//   take effect at once and must be made while the block is idle; the block does not enforce this.
`default_nettype none

module fit_policy_block_allocator #(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // configuration write port
  input  wire                        cfg_we_i,
  input  wire [fpba_pkg::CFGA_W-1:0] cfg_idx_i,
  input  wire [fpba_pkg::CFG_W-1:0]  cfg_data_i,
  // input stream
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire [39:0]                 s_axis_tdata,  // block_index[3:0], block_size[19:4],
                                                    // request_size[35:20], zero[39:36]
  input  wire [fpba_pkg::CMD_W-1:0]  s_axis_tuser,  // cmd[1:0]
  // result stream
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // assigned_block[3:0], space_left[19:4],
                                                    // zero[23:20]
  output logic                       m_axis_tuser   // granted
);
  import fpba_pkg::*;

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WB   = 3'd2;
  localparam logic [2:0] S_REST = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // input fields
  logic [CMD_W-1:0]   in_cmd;
  logic [BIDX_W-1:0]  in_idx;
  logic [FSIZE_W-1:0] in_size;
  logic [FSIZE_W-1:0] in_req;
  logic               in_acc;
  logic               out_acc;

  assign in_cmd  = s_axis_tuser;
  assign in_idx  = s_axis_tdata[3:0];
  assign in_size = s_axis_tdata[19:4];
  assign in_req  = s_axis_tdata[35:20];

  // configuration registers
  logic [MODE_W-1:0] fit_mode_q;
  logic [BCNT_W-1:0] block_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= FIT_MODE_RST;
      block_count_q <= BLOCK_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIT_MODE:    fit_mode_q    <= cfg_data_i[MODE_W-1:0];
        REG_BLOCK_COUNT: block_count_q <= cfg_data_i[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     limit_q, limit_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic [SIZE_BITS-1:0] req_q, req_d;
  logic [NUM_BLOCKS-1:0] lv_q, lv_d;  // loaded table entry written
  logic [NUM_BLOCKS-1:0] fv_q, fv_d;  // free table entry written
  logic                 res_granted_q, res_granted_d;
  logic [BIDX_W-1:0]    res_blk_q, res_blk_d;
  logic [FSIZE_W-1:0]   res_space_q, res_space_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_granted_q;
  logic [BIDX_W-1:0]    out_blk_q;
  logic [FSIZE_W-1:0]   out_space_q;

  // RAM ports
  logic                 ls_we, ls_re, fs_we, fs_re;
  logic [IDX_W-1:0]     ls_waddr, fs_waddr, rd_addr;
  logic [SIZE_BITS-1:0] ls_wdata, fs_wdata, ls_rdata, fs_rdata;

  // selection unit
  pick_ctrl_t           pick_ctrl;
  logic                 pick_found;
  logic [IDX_W-1:0]     pick_idx;
  logic [SIZE_BITS-1:0] pick_val;
  logic [SIZE_BITS-1:0] cand_space;
  logic [SIZE_BITS-1:0] wb_space;
  logic [IDX_W-1:0]     load_addr;
  logic                 load_in_range;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  assign load_addr     = IDX_W'(in_idx);
  assign load_in_range = (32'(in_idx) < NUM_BLOCKS);
  assign rd_addr       = IDX_W'(cnt_q);
  assign cand_space    = fv_q[rd_idx_q] ? fs_rdata : '0;
  assign wb_space      = pick_val - req_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    limit_d       = limit_q;
    rd_vld_d      = 1'b0;
    rd_idx_d      = rd_idx_q;
    req_d         = req_q;
    lv_d          = lv_q;
    fv_d          = fv_q;
    res_granted_d = res_granted_q;
    res_blk_d     = res_blk_q;
    res_space_d   = res_space_q;
    out_valid_d   = out_valid_q && !out_acc;
    ls_we         = 1'b0;
    ls_waddr      = load_addr;
    ls_wdata      = SIZE_BITS'(in_size);
    ls_re         = 1'b0;
    fs_we         = 1'b0;
    fs_waddr      = load_addr;
    fs_wdata      = SIZE_BITS'(in_size);
    fs_re         = 1'b0;
    pick_ctrl     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_granted_d = 1'b0;
          res_blk_d     = '0;
          res_space_d   = '0;
          cnt_d         = '0;
          state_d       = S_DONE;
          case (in_cmd)
            CMD_LOAD: begin
              if (load_in_range) begin
                ls_we           = 1'b1;
                fs_we           = 1'b1;
                lv_d[load_addr] = 1'b1;
                fv_d[load_addr] = 1'b1;
              end
            end
            CMD_ALLOC: begin
              req_d           = SIZE_BITS'(in_req);
              pick_ctrl.clear = 1'b1;
              if (32'(block_count_q) > NUM_BLOCKS) begin
                limit_d = CNT_W'(NUM_BLOCKS);
              end else begin
                limit_d = CNT_W'(block_count_q);
              end
              state_d = S_SCAN;
            end
            CMD_RESTORE: begin
              // entries never loaded read as zero from here on
              fv_d    = lv_q;
              state_d = S_REST;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // issue one read per cycle, judge the entry read the cycle before
        if (cnt_q < limit_q) begin
          fs_re    = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = rd_addr;
          cnt_d    = cnt_q + 1'b1;
        end
        pick_ctrl.sample = rd_vld_q;
        if (!(cnt_q < limit_q) && !rd_vld_q) begin
          state_d = S_WB;
        end
      end

      S_WB: begin
        // write the reduced free space back to the chosen entry
        if (pick_found) begin
          fs_we          = 1'b1;
          fs_waddr       = pick_idx;
          fs_wdata       = wb_space;
          fv_d[pick_idx] = 1'b1;
          res_granted_d  = 1'b1;
          res_blk_d      = BIDX_W'(pick_idx);
          res_space_d    = FSIZE_W'(wb_space);
        end
        state_d = S_DONE;
      end

      S_REST: begin
        // copy loaded sizes into the free table, one entry per cycle
        if (cnt_q < CNT_W'(NUM_BLOCKS)) begin
          ls_re    = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = rd_addr;
          cnt_d    = cnt_q + 1'b1;
        end
        if (rd_vld_q) begin
          fs_we    = 1'b1;
          fs_waddr = rd_idx_q;
          fs_wdata = ls_rdata;
        end
        if (!(cnt_q < CNT_W'(NUM_BLOCKS)) && !rd_vld_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      limit_q     <= '0;
      rd_vld_q    <= 1'b0;
      lv_q        <= '0;
      fv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      limit_q     <= limit_d;
      rd_vld_q    <= rd_vld_d;
      lv_q        <= lv_d;
      fv_q        <= fv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q      <= rd_idx_d;
    req_q         <= req_d;
    res_granted_q <= res_granted_d;
    res_blk_q     <= res_blk_d;
    res_space_q   <= res_space_d;
    if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
      out_granted_q <= res_granted_q;
      out_blk_q     <= res_blk_q;
      out_space_q   <= res_space_q;
    end
  end

  // table of sizes as loaded
  fpba_ram #(
    .WIDTH(SIZE_BITS),
    .DEPTH(NUM_BLOCKS)
  ) u_loaded_ram (
    .clk_i  (clk_i),
    .we_i   (ls_we),
    .waddr_i(ls_waddr),
    .wdata_i(ls_wdata),
    .re_i   (ls_re),
    .raddr_i(rd_addr),
    .rdata_o(ls_rdata)
  );

  // table of free space
  fpba_ram #(
    .WIDTH(SIZE_BITS),
    .DEPTH(NUM_BLOCKS)
  ) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (fs_we),
    .waddr_i(fs_waddr),
    .wdata_i(fs_wdata),
    .re_i   (fs_re),
    .raddr_i(rd_addr),
    .rdata_o(fs_rdata)
  );

  fpba_pick #(
    .IDX_W (IDX_W),
    .SIZE_W(SIZE_BITS)
  ) u_pick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (pick_ctrl),
    .mode_i (fit_mode_q),
    .req_i  (req_q),
    .idx_i  (rd_idx_q),
    .space_i(cand_space),
    .found_o(pick_found),
    .idx_o  (pick_idx),
    .val_o  (pick_val)
  );

  // result stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_granted_q;
  assign m_axis_tdata  = {4'b0000, out_space_q, out_blk_q};

`ifndef SYNTH
  // the scan never reads past its limit, which never exceeds the table
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q <= limit_q && 32'(limit_q) <= NUM_BLOCKS))
    else $error("scan counter out of range");
  // a load in range marks both table entries as written
  a_load_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_cmd == CMD_LOAD && load_in_range)
      |=> (lv_q[$past(load_addr)] && fv_q[$past(load_addr)]))
    else $error("load did not mark its entry");
  // a grant written back never underflows
  a_wb_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && pick_found) |-> (pick_val >= req_q))
    else $error("write-back underflows");
  // no result is dropped while the receiver stalls
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(m_axis_tdata)))
    else $error("pending result lost");
`endif

endmodule

`default_nettype wire

/* src/fpba_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data is registered and appears in the cycle after the read enable. No dependencies.
`default_nettype none

module fpba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire                                      clk_i,
  input  wire                                      we_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire [WIDTH-1:0]                          wdata_i,
  input  wire                                      re_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/fpba_pick.sv */
// Selection unit: sees one candidate entry per cycle and keeps the best
// fitting one under the current policy. Uses fpba_pkg.
`default_nettype none

module fpba_pick #(
  parameter int unsigned IDX_W  = 4,
  parameter int unsigned SIZE_W = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  fpba_pkg::pick_ctrl_t       ctrl_i,
  input  wire [fpba_pkg::MODE_W-1:0] mode_i,
  input  wire [SIZE_W-1:0]           req_i,
  input  wire [IDX_W-1:0]            idx_i,
  input  wire [SIZE_W-1:0]           space_i,
  output logic                       found_o,
  output logic [IDX_W-1:0]           idx_o,
  output logic [SIZE_W-1:0]          val_o
);
  import fpba_pkg::*;

  logic              found_q, found_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SIZE_W-1:0] val_q, val_d;
  logic              fits, take;

  // a fitting candidate is taken if none is held or, in best/worst fit, if strictly better; ties keep the lower index
  always_comb begin
    fits = (space_i >= req_i);
    take = 1'b0;
    if (fits) begin
      if (!found_q) begin
        take = 1'b1;
      end else if (mode_i == MODE_BEST) begin
        take = (space_i < val_q);
      end else if (mode_i == MODE_WORST) begin
        take = (space_i > val_q);
      end
    end
  end

  always_comb begin
    found_d = found_q;
    idx_d   = idx_q;
    val_d   = val_q;
    if (ctrl_i.clear) begin
      found_d = 1'b0;
    end else if (ctrl_i.sample && take) begin
      found_d = 1'b1;
      idx_d   = idx_i;
      val_d   = space_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    val_q <= val_d;
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;
  assign val_o   = val_q;

`ifndef SYNTH
  // a held choice always fits the request it was found for
  a_held_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.sample && !ctrl_i.clear && take) |=> (val_q >= $past(req_i)))
    else $error("selected entry does not fit");
  // first fit never replaces a choice once made
  a_first_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && !ctrl_i.clear && mode_i != MODE_BEST && mode_i != MODE_WORST)
      |=> (found_q && idx_q == $past(idx_q)))
    else $error("first fit replaced its choice");
  // clearing drops the choice
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> !found_q)
    else $error("choice survived a clear");
`endif

endmodule

`default_nettype wire

/* dv/fpba_grant_checker.sv */
`timescale 1ns / 1ps
// Checker for the fit-policy block allocator testbench: watches config writes and both
// stream channels, predicts every result and compares it field by field. Uses fpba_pkg.

module fpba_grant_checker #(
  parameter int unsigned NUM_BLOCKS = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [fpba_pkg::CFGA_W-1:0]       cfg_idx_i,
  input  wire [fpba_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire                              s_valid_i,
  input  wire                              s_ready_i,
  input  wire [39:0]                       s_data_i,  // block_index, block_size,
                                                      // request_size, zero
  input  wire [fpba_pkg::CMD_W-1:0]        s_user_i,  // cmd
  input  wire                              m_valid_i,
  input  wire                              m_ready_i,
  input  wire [23:0]                       m_data_i,  // assigned_block, space_left, zero
  input  wire                              m_user_i,  // granted
  output int                               pending_o,
  output int                               errors_o
);

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic                             granted;
    logic [fpba_pkg::BIDX_W-1:0]      block;
    logic [fpba_pkg::FSIZE_W-1:0]     left;
  } grant_t;

  // Shadow copy of the block's tables and registers
  logic [fpba_pkg::FSIZE_W-1:0] size_loaded [NUM_BLOCKS];
  logic [fpba_pkg::FSIZE_W-1:0] free_left   [NUM_BLOCKS];
  logic [fpba_pkg::MODE_W-1:0]  mode_q;
  logic [fpba_pkg::BCNT_W-1:0]  count_q;

  grant_t grant_q [$];
  grant_t want;
  grant_t got;

  initial begin
    pending_o = 0;
    errors_o  = 0;
  end

  // Apply one transaction to the shadow state and return the result it should give
  function automatic grant_t predict_grant(input logic [fpba_pkg::CMD_W-1:0] cmd,
                                           input logic [fpba_pkg::BIDX_W-1:0] idx,
                                           input logic [fpba_pkg::FSIZE_W-1:0] size,
                                           input logic [fpba_pkg::FSIZE_W-1:0] req);
    grant_t r;
    int     limit;
    int     pick;
    r = '0;
    case (cmd)
      fpba_pkg::CMD_LOAD: begin
        size_loaded[idx] = size;
        free_left[idx]   = size;
      end
      fpba_pkg::CMD_ALLOC: begin
        limit = (count_q > NUM_BLOCKS) ? NUM_BLOCKS : int'(count_q);
        pick  = -1;
        // first fit keeps the first hit; best/worst replace only on a strict improvement
        for (int j = 0; j < limit; j++) begin
          if (free_left[j] >= req) begin
            if (pick < 0)
              pick = j;
            else if (mode_q == fpba_pkg::MODE_BEST && free_left[j] < free_left[pick])
              pick = j;
            else if (mode_q == fpba_pkg::MODE_WORST && free_left[j] > free_left[pick])
              pick = j;
          end
        end
        if (pick >= 0) begin
          free_left[pick] = free_left[pick] - req;
          r.granted = 1'b1;
          r.block   = pick[fpba_pkg::BIDX_W-1:0];
          r.left    = free_left[pick];
        end
      end
      fpba_pkg::CMD_RESTORE: begin
        for (int j = 0; j < NUM_BLOCKS; j++)
          free_left[j] = size_loaded[j];
      end
      default: ;  // unused kind changes nothing
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      if (errors_o < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors_o = errors_o + 1;
    end
  endtask

  // Track config, predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  = fpba_pkg::FIT_MODE_RST;
      count_q = fpba_pkg::BLOCK_COUNT_RST;
      for (int j = 0; j < NUM_BLOCKS; j++) begin
        size_loaded[j] = '0;
        free_left[j]   = '0;
      end
      grant_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fpba_pkg::REG_FIT_MODE:    mode_q  = cfg_data_i[fpba_pkg::MODE_W-1:0];
          fpba_pkg::REG_BLOCK_COUNT: count_q = cfg_data_i[fpba_pkg::BCNT_W-1:0];
          default: ;
        endcase
      end
      if (m_valid_i && m_ready_i) begin
        got.granted = m_user_i;
        got.block   = m_data_i[3:0];
        got.left    = m_data_i[19:4];
        if (grant_q.size() == 0) begin
          if (errors_o < MAX_REPORTS)
            $display("%0t: result with nothing expected, expected none, actual %0h",
                     $time, got);
          errors_o = errors_o + 1;
        end else begin
          want = grant_q.pop_front();
          check_field("granted", want.granted, got.granted);
          check_field("assigned_block", want.block, got.block);
          check_field("space_left", want.left, got.left);
        end
      end
      if (s_valid_i && s_ready_i)
        grant_q.push_back(predict_grant(s_user_i, s_data_i[3:0], s_data_i[19:4],
                                        s_data_i[35:20]));
      pending_o = grant_q.size();
    end
  end

endmodule

/* dv/fit_policy_block_allocator_test.sv */
`timescale 1ns / 1ps
// Top of the fit-policy block allocator testbench: clock, reset, stimulus and verdict.
// Depends on fpba_pkg, fit_policy_block_allocator and fpba_grant_checker.

module fit_policy_block_allocator_test;

  localparam int unsigned NUM_BLOCKS     = 16;
  localparam int unsigned SIZE_BITS      = 16;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 32;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          RUNS_PER_PHASE = 8;
  localparam int          RUN_ITEMS      = 40;

  localparam logic [fpba_pkg::CMD_W-1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [fpba_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          cfg_we     = 1'b0;
  logic [fpba_pkg::CFGA_W-1:0]   cfg_idx    = '0;
  logic [fpba_pkg::CFG_W-1:0]    cfg_data   = '0;
  logic                          s_valid    = 1'b0;
  logic                          s_ready;
  logic [39:0]                   s_data     = '0;
  logic [fpba_pkg::CMD_W-1:0]    s_user     = '0;
  logic                          m_valid;
  logic                          m_ready    = 1'b0;
  logic [23:0]                   m_data;
  logic                          m_user;

  int pending;
  int errors;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_req      = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  fit_policy_block_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user)
  );

  fpba_grant_checker #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .s_valid_i (s_valid),
    .s_ready_i (s_ready),
    .s_data_i  (s_data),
    .s_user_i  (s_user),
    .m_valid_i (m_valid),
    .m_ready_i (m_ready),
    .m_data_i  (m_data),
    .m_user_i  (m_user),
    .pending_o (pending),
    .errors_o  (errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result receiver: random back-pressure, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one item; entered and left at a falling edge, valid stays up for a follow-on
  task automatic send_item(input logic [fpba_pkg::CMD_W-1:0]   cmd,
                           input logic [fpba_pkg::BIDX_W-1:0]  idx,
                           input logic [fpba_pkg::FSIZE_W-1:0] size,
                           input logic [fpba_pkg::FSIZE_W-1:0] req);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {4'b0, req, size, idx};
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every result is back and the block is quiet
  task automatic settle();
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [fpba_pkg::MODE_W-1:0] mode,
                            input logic [fpba_pkg::BCNT_W-1:0] count);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= fpba_pkg::REG_FIT_MODE;
    cfg_data <= {{(fpba_pkg::CFG_W - fpba_pkg::MODE_W){1'b0}}, mode};
    @(negedge clk_i);
    cfg_idx  <= fpba_pkg::REG_BLOCK_COUNT;
    cfg_data <= count;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [fpba_pkg::FSIZE_W-1:0] rand_size();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(0, 255));
      2:       return 16'($urandom_range(0, 4095));
      default: return 16'(16'hFFFF - $urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [fpba_pkg::FSIZE_W-1:0] rand_request();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(0, 255));
      2:       return 16'($urandom_range(0, 4095));
      default: return 16'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic logic [fpba_pkg::BCNT_W-1:0] rand_count();
    case ($urandom_range(9))
      0:       return 5'd0;
      1:       return 5'($urandom_range(1, 4));
      2:       return 5'($urandom_range(17, 31));
      3, 4:    return 5'($urandom_range(5, 15));
      default: return 5'd16;
    endcase
  endfunction

  // Mostly allocations, with loads, restores and unused kinds mixed in
  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 18)
      send_item(fpba_pkg::CMD_LOAD, 4'($urandom), rand_size(), 16'($urandom));
    else if (pick < 80)
      send_item(fpba_pkg::CMD_ALLOC, 4'($urandom), 16'($urandom), rand_request());
    else if (pick < 88)
      send_item(fpba_pkg::CMD_RESTORE, 4'($urandom), 16'($urandom), 16'($urandom));
    else
      send_item(CMD_UNUSED, 4'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    src_idle_pct  = 17;
    sink_idle_pct = 54;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty tables under reset config, zero and full-scale requests
    send_item(fpba_pkg::CMD_ALLOC, 4'd0, 16'd0, 16'd0);
    send_item(fpba_pkg::CMD_ALLOC, 4'd0, 16'd0, 16'hFFFF);
    send_item(fpba_pkg::CMD_LOAD, 4'd0, 16'hFFFF, 16'd0);
    send_item(fpba_pkg::CMD_LOAD, 4'd1, 16'd100, 16'd0);
    send_item(fpba_pkg::CMD_LOAD, 4'd2, 16'd50, 16'd0);
    send_item(fpba_pkg::CMD_LOAD, 4'd3, 16'd200, 16'd0);
    send_item(fpba_pkg::CMD_LOAD, 4'd4, 16'd50, 16'd0);
    send_item(fpba_pkg::CMD_LOAD, 4'd15, 16'h8000, 16'd0);
    send_item(fpba_pkg::CMD_ALLOC, 4'd0, 16'd0, 16'd60);
    send_item(CMD_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF);
    send_item(fpba_pkg::CMD_RESTORE, 4'd0, 16'd0, 16'd0);
    // best fit with ties, count above the table
    set_config(fpba_pkg::MODE_BEST, 5'd31);
    send_item(fpba_pkg::CMD_ALLOC, 4'd0, 16'd0, 16'd50);
    send_item(fpba_pkg::CMD_ALLOC, 4'd0, 16'd0, 16'd50);
    send_item(fpba_pkg::CMD_ALLOC, 4'd0, 16'd0, 16'd0);
    set_config(fpba_pkg::MODE_WORST, 5'd16);
    send_item(fpba_pkg::CMD_ALLOC, 4'd0, 16'd0, 16'h8000);
    send_item(fpba_pkg::CMD_ALLOC, 4'd0, 16'd0, 16'h7FFF);
    // unused mode, no blocks in range
    set_config(MODE_UNUSED, 5'd0);
    send_item(fpba_pkg::CMD_ALLOC, 4'd0, 16'd0, 16'd0);
    set_config(MODE_UNUSED, 5'd1);
    send_item(fpba_pkg::CMD_ALLOC, 4'd0, 16'd0, 16'd1);
    send_item(fpba_pkg::CMD_RESTORE, 4'd0, 16'd0, 16'd0);
    send_item(fpba_pkg::CMD_LOAD, 4'd5, 16'hAAAA, 16'd0);
    send_item(fpba_pkg::CMD_LOAD, 4'd10, 16'h5555, 16'd0);
    set_config(MODE_UNUSED, 5'd16);
    send_item(fpba_pkg::CMD_ALLOC, 4'd0, 16'd0, 16'h5555);

    // Random runs: fill the table, restore, then a mixed workload
    for (int phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin
          src_idle_pct  = 17;
          sink_idle_pct = 54;
        end
        1: begin
          src_idle_pct  = 54;
          sink_idle_pct = 17;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int run = 0; run < RUNS_PER_PHASE; run++) begin
        set_config(2'($urandom_range(0, 3)), rand_count());
        for (int j = 0; j < NUM_BLOCKS; j++)
          if ($urandom_range(9) != 0)
            send_item(fpba_pkg::CMD_LOAD, 4'(j), rand_size(), 16'($urandom));
        send_item(fpba_pkg::CMD_RESTORE, 4'($urandom), 16'($urandom), 16'($urandom));
        // long receiver stall while items keep coming, to fill the block
        if (phase == 2 && run == 2)
          hold_req = HOLD_CYCLES;
        repeat (RUN_ITEMS) random_item();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
